>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds see empty macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> hdl/qft_pkg.sv
package qft_pkg;

   // Line and token limits.
   localparam int unsigned MAX_LINE_CHARS = 256;
   localparam int unsigned MAX_TOKENS     = 16;
   localparam int unsigned POS_W          = $clog2(MAX_LINE_CHARS + 1);
   localparam int unsigned TOK_W          = 5;

   localparam logic [TOK_W-1:0] LIMIT_RESET = TOK_W'(MAX_TOKENS);

   // Result kinds.
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_CHAR = 2'd0;
   localparam kind_type KIND_END  = 2'd1;
   localparam kind_type KIND_DONE = 2'd2;

   // Character codes.
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_COMMA  = 8'h2c;
   localparam logic [7:0] CH_EQUAL  = 8'h3d;

   // Register map: the register index is address bit 2.
   localparam logic REG_TOKEN_LIMIT = 1'b0;

   // Result queue geometry.
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_AW    = 2;
   localparam int unsigned Q_CW    = 3;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  byte_value;
      logic [3:0]  token_index;
      logic [4:0]  token_count;
      logic        last;
   } result_type;

endpackage

>>> hdl/quoted_field_tokenizer.sv
// Channel   Dir  Payload                                      Handshake
// req_      in   tdata[7:0] in_byte                           tvalid/tready
// rsp_      out  tdata byte/index/count, tuser kind, tlast    tvalid/tready
// csr_      in   APB, token_limit at address 0                psel/penable
//
// Results of a byte appear at the output in the cycle after it is taken, at the earliest.
// Each byte gives up to two results; the four-entry result queue drains one per cycle while
// rsp_tready is high, so the input takes one byte per cycle while the queue has two free places.
// Reset is synchronous and active high; it clears the line state and the queue.
// A stalled output holds back the input once fewer than two queue places are free.
`include "assert_macros.svh"

module quoted_field_tokenizer
   import qft_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] byte_value, [11:8] token_index,
                                    // [16:12] token_count, [23:17] zero
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast,   // last_in_step
   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [TOK_W-1:0] limit_ff;
   logic [TOK_W-1:0] eff_limit;

   logic [7:0]       prev_char_ff,  prev_char_in;
   logic [POS_W-1:0] pos_ff,        pos_in;
   logic             quote_ff,      quote_in;
   logic             pending_ff,    pending_in;
   logic             open_ff,       open_in;
   logic [TOK_W-1:0] token_ff,      token_in;
   logic             closed_ff,     closed_in;

   logic             req_accept;
   logic             rsp_pop;
   logic             csr_write;
   logic [7:0]       c;
   logic             c_quote;
   logic             flush;
   result_type       res [2];
   logic [1:0]       nres;

   result_type       q_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff;
   logic [Q_AW-1:0]  rd_ptr_ff;
   logic [Q_CW-1:0]  cnt_ff;
   logic [1:0]       push_n;

   // Configuration register access.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_TOKEN_LIMIT) ? {27'd0, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write && csr_paddr[2] == REG_TOKEN_LIMIT) begin
         limit_ff <= csr_pwdata[TOK_W-1:0];
      end
   end

   // A limit of zero acts as one, and anything above the maximum as the maximum.
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = TOK_W'(1);
      end else if (limit_ff > TOK_W'(MAX_TOKENS)) begin
         eff_limit = TOK_W'(MAX_TOKENS);
      end else begin
         eff_limit = limit_ff;
      end
   end

   // Handshakes.
   assign req_tready = (cnt_ff <= Q_CW'(Q_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   // Separators are folded onto the space character.
   always_comb begin
      if (req_tdata == CH_EQUAL || req_tdata == CH_COMMA || req_tdata == CH_TAB) begin
         c = CH_SPACE;
      end else begin
         c = req_tdata;
      end
   end
   assign c_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
   assign flush   = pending_ff || open_ff;

   // Per-byte decision: next line state and up to two results.
   always_comb begin
      prev_char_in = prev_char_ff;
      pos_in       = pos_ff;
      quote_in     = quote_ff;
      pending_in   = pending_ff;
      open_in      = open_ff;
      token_in     = token_ff;
      closed_in    = closed_ff;
      nres         = 2'd0;
      res[0]       = '0;
      res[1]       = '0;

      if (req_tdata == CH_NUL) begin
         // End of line: close any open token, report the count and start afresh.
         if (flush) begin
            res[nres[0]] = '{kind: KIND_END, byte_value: 8'd0,
                             token_index: token_ff[3:0], token_count: 5'd0, last: 1'b0};
            nres = nres + 2'd1;
         end
         res[nres[0]] = '{kind: KIND_DONE, byte_value: 8'd0, token_index: 4'd0,
                          token_count: token_ff + TOK_W'(flush), last: 1'b0};
         nres = nres + 2'd1;
         prev_char_in = CH_SPACE;
         pos_in       = '0;
         quote_in     = 1'b0;
         pending_in   = 1'b0;
         open_in      = 1'b0;
         token_in     = '0;
         closed_in    = 1'b0;
      end else if (closed_ff || pos_ff >= POS_W'(MAX_LINE_CHARS)) begin
         // Rest of the line is ignored.
      end else if (pos_ff == '0 && (req_tdata == CH_HASH || req_tdata == CH_BANG)) begin
         closed_in = 1'b1;
      end else if (req_tdata == CH_CR || req_tdata == CH_LF) begin
         closed_in = 1'b1;
      end else if (pending_ff && c == CH_SPACE) begin
         // A quote followed by a space closes the field; the space is swallowed.
         pending_in = 1'b0;
         quote_in   = 1'b0;
         res[0] = '{kind: KIND_END, byte_value: 8'd0, token_index: token_ff[3:0],
                    token_count: 5'd0, last: 1'b0};
         nres       = 2'd1;
         token_in   = token_ff + TOK_W'(1);
         open_in    = 1'b0;
         if (token_ff + TOK_W'(1) >= eff_limit) begin
            closed_in = 1'b1;
         end
         prev_char_in = CH_SPACE;
         pos_in       = pos_ff + POS_W'(1);
      end else begin
         // A waiting quote that was not a close becomes a token character.
         if (pending_ff) begin
            pending_in = 1'b0;
            res[0] = '{kind: KIND_CHAR, byte_value: prev_char_ff,
                       token_index: token_ff[3:0], token_count: 5'd0, last: 1'b0};
            nres    = 2'd1;
            open_in = 1'b1;
         end
         if (c_quote && quote_ff) begin
            pending_in = 1'b1;
         end else if (c_quote && (pos_ff == '0 || prev_char_ff == CH_SPACE)) begin
            quote_in = 1'b1;
         end else if (quote_ff || c != CH_SPACE) begin
            res[nres[0]] = '{kind: KIND_CHAR, byte_value: c, token_index: token_ff[3:0],
                             token_count: 5'd0, last: 1'b0};
            nres    = nres + 2'd1;
            open_in = 1'b1;
         end else if (pos_ff != '0 && prev_char_ff != CH_SPACE) begin
            res[nres[0]] = '{kind: KIND_END, byte_value: 8'd0,
                             token_index: token_ff[3:0], token_count: 5'd0, last: 1'b0};
            nres     = nres + 2'd1;
            token_in = token_ff + TOK_W'(1);
            open_in  = 1'b0;
            if (token_ff + TOK_W'(1) >= eff_limit) begin
               closed_in = 1'b1;
            end
         end
         prev_char_in = c;
         pos_in       = pos_ff + POS_W'(1);
      end

      // Flag the final result of this byte.
      if (nres == 2'd2) begin
         res[1].last = 1'b1;
      end else if (nres == 2'd1) begin
         res[0].last = 1'b1;
      end
   end

   // Line state advances on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_char_ff <= CH_SPACE;
         pos_ff       <= '0;
         quote_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         open_ff      <= 1'b0;
         token_ff     <= '0;
         closed_ff    <= 1'b0;
      end else if (req_accept) begin
         prev_char_ff <= prev_char_in;
         pos_ff       <= pos_in;
         quote_ff     <= quote_in;
         pending_ff   <= pending_in;
         open_ff      <= open_in;
         token_ff     <= token_in;
         closed_ff    <= closed_in;
      end
   end

   // Result queue.
   assign push_n = req_accept ? nres : 2'd0;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= res[0];
      end
      if (push_n == 2'd2) begin
         q_ff[wr_ptr_ff + Q_AW'(1)] <= res[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + Q_AW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + Q_AW'(rsp_pop);
         cnt_ff    <= cnt_ff + Q_CW'(push_n) - Q_CW'(rsp_pop);
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = q_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = q_ff[rd_ptr_ff].last;
   assign rsp_tdata  = {7'd0, q_ff[rd_ptr_ff].token_count,
                        q_ff[rd_ptr_ff].token_index, q_ff[rd_ptr_ff].byte_value};

   // Checks on the queue and the line state.
   `ASSERT_NEVER(a_queue_over, clock, reset, cnt_ff > Q_CW'(Q_DEPTH), "result queue overflow")
   `ASSERT_PROP(a_done_last, clock, reset, (rsp_tvalid && rsp_tuser == KIND_DONE) |-> rsp_tlast, "line done result not marked last")
   `ASSERT_NEVER(a_token_range, clock, reset, token_ff > TOK_W'(MAX_TOKENS), "token counter beyond maximum")
   `ASSERT_PROP(a_line_clear, clock, reset, (req_accept && req_tdata == CH_NUL) |=> (token_ff == '0 && !open_ff && !pending_ff && !closed_ff), "line state not cleared after end of line")
   `ASSERT_NEVER(a_pos_range, clock, reset, pos_ff > POS_W'(MAX_LINE_CHARS), "character position beyond line limit")

endmodule
